// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// shared widths, constants and helpers of the transitive closure core
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int MAX_NODES = 16;
   localparam int ROW_W     = 16;
   localparam int IDX_W     = 4;
   localparam int CNT_W     = 5;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // node count limited to 1 .. MAX_NODES
   function automatic cnt_type clamp_nodes(input cnt_type cnt);
      cnt_type res;
      res = cnt;
      if (cnt == '0) begin
         res = CNT_W'(1);
      end else if (cnt > CNT_W'(MAX_NODES)) begin
         res = CNT_W'(MAX_NODES);
      end
      return res;
   endfunction

   // ones in the low cnt bits
   function automatic row_type node_mask(input cnt_type cnt);
      logic [ROW_W:0] wide;
      wide = ((ROW_W+1)'(1) << cnt) - (ROW_W+1)'(1);
      return wide[ROW_W-1:0];
   endfunction

endpackage

// ===== rtl/transitive_closure_connectivity_core.sv =====
// ----------------------------------------------------------------------------
// transitive_closure_connectivity_core
// warshall closure and strong connectivity of a directed graph of up to 16
// nodes, one adjacency row in per item, one reachability row out per item
// ----------------------------------------------------------------------------
// usage: set csr_node_count (n) while idle, then send adjacency rows on the
// req_ channel, one per item, the final one with req_last set. rows at or
// above n are dropped, bits at or above n are ignored. rows persist between
// runs, so a later run may reload only some rows.
// a row without last is taken whenever the core is idle. the last item starts the run,
// during which req_stall stays high. the run is set by one shared row unit
// and one port on the closure memory, each row step a read state and then a
// write, evaluate or send state: copy of n rows, then n pivots, each a pivot
// row load and then n rows, check of n rows, emission of n rows, plus any rsp_stall time.
// results leave on the rsp_ channel, rows 0 .. n-1 in order, each with the
// strong connectivity flag, rsp_last_row on row n-1. a held rsp_stall holds
// the output register and the emission waits. reset clears control state
// and sets n to 1; adjacency rows read as undefined until loaded.
// ----------------------------------------------------------------------------
module transitive_closure_connectivity_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [4:0]            csr_node_count,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_row_index,
   input  logic [15:0]           req_row_bits,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_out_row,
   output logic [15:0]           rsp_reach_bits,
   output logic                  rsp_strongly_connected,
   output logic                  rsp_last_row
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_ROW_RD,
      ST_ROW_WR,
      ST_CHK_RD,
      ST_CHK_EVAL,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   state_type          state_ff;
   tcc_pkg::cnt_type   node_count_ff;
   tcc_pkg::idx_type   i_ff;
   tcc_pkg::idx_type   k_ff;
   tcc_pkg::row_type   pivot_ff;
   logic               conn_ff;
   logic               rsp_valid_ff;
   tcc_pkg::idx_type   rsp_row_ff;
   tcc_pkg::row_type   rsp_bits_ff;
   logic               rsp_conn_ff;
   logic               rsp_last_ff;

   tcc_pkg::row_type   adj_mem [tcc_pkg::MAX_NODES];
   tcc_pkg::row_type   clo_mem [tcc_pkg::MAX_NODES];
   tcc_pkg::row_type   adj_rd_ff;
   tcc_pkg::row_type   clo_rd_ff;

   tcc_pkg::cnt_type   n_eff;
   tcc_pkg::idx_type   last_idx;
   tcc_pkg::row_type   mask;
   logic               req_take;
   logic               adj_we;
   logic               clo_we;
   tcc_pkg::row_type   clo_wdata;
   tcc_pkg::idx_type   clo_raddr;
   logic               out_free;
   logic               i_end;
   tcc_pkg::cnt_type   cnt_tmp;

   always_comb begin
      n_eff     = tcc_pkg::clamp_nodes(node_count_ff);
      cnt_tmp   = n_eff - tcc_pkg::CNT_W'(1);
      last_idx  = cnt_tmp[tcc_pkg::IDX_W-1:0];
      mask      = tcc_pkg::node_mask(n_eff);
      req_take  = req_valid && (state_ff == ST_IDLE);
      adj_we    = req_take && ({1'b0, req_row_index} < n_eff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      i_end     = (i_ff == last_idx);
      clo_raddr = (state_ff == ST_PIV_RD) ? k_ff : i_ff;
      clo_we    = 1'b0;
      clo_wdata = clo_rd_ff | pivot_ff;
      case (state_ff)
         ST_COPY_WR: begin
            clo_we    = 1'b1;
            clo_wdata = adj_rd_ff & mask;
         end
         ST_ROW_WR: begin
            clo_we = clo_rd_ff[k_ff];
         end
         default: begin
            clo_we = 1'b0;
         end
      endcase
   end

   // adjacency and closure memories
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[req_row_index] <= req_row_bits & mask;
      end
      adj_rd_ff <= adj_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (clo_we) begin
         clo_mem[i_ff] <= clo_wdata;
      end
      clo_rd_ff <= clo_mem[clo_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tcc_pkg::CNT_W'(1);
      end else if (csr_we) begin
         node_count_ff <= csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         k_ff         <= '0;
         conn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT_SEND)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take && req_last) begin
                  i_ff     <= '0;
                  state_ff <= ST_COPY_RD;
               end
            end
            ST_COPY_RD: begin
               state_ff <= ST_COPY_WR;
            end
            ST_COPY_WR: begin
               if (i_end) begin
                  i_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_PIV_RD;
               end else begin
                  i_ff     <= i_ff + tcc_pkg::IDX_W'(1);
                  state_ff <= ST_COPY_RD;
               end
            end
            ST_PIV_RD: begin
               state_ff <= ST_PIV_LD;
            end
            ST_PIV_LD: begin
               pivot_ff <= clo_rd_ff;
               i_ff     <= '0;
               state_ff <= ST_ROW_RD;
            end
            ST_ROW_RD: begin
               state_ff <= ST_ROW_WR;
            end
            ST_ROW_WR: begin
               if (i_end) begin
                  i_ff <= '0;
                  if (k_ff == last_idx) begin
                     conn_ff  <= 1'b1;
                     state_ff <= ST_CHK_RD;
                  end else begin
                     k_ff     <= k_ff + tcc_pkg::IDX_W'(1);
                     state_ff <= ST_PIV_RD;
                  end
               end else begin
                  i_ff     <= i_ff + tcc_pkg::IDX_W'(1);
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_CHK_RD: begin
               state_ff <= ST_CHK_EVAL;
            end
            ST_CHK_EVAL: begin
               // a lone node needs a self-loop
               if (n_eff == tcc_pkg::CNT_W'(1)) begin
                  conn_ff <= clo_rd_ff[0];
               end else if (((clo_rd_ff | (tcc_pkg::ROW_W'(1) << i_ff)) & mask) != mask) begin
                  conn_ff <= 1'b0;
               end
               if (i_end) begin
                  i_ff     <= '0;
                  state_ff <= ST_OUT_RD;
               end else begin
                  i_ff     <= i_ff + tcc_pkg::IDX_W'(1);
                  state_ff <= ST_CHK_RD;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= i_ff;
                  rsp_bits_ff  <= clo_rd_ff;
                  rsp_conn_ff  <= conn_ff;
                  rsp_last_ff  <= i_end;
                  if (i_end) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_ff + tcc_pkg::IDX_W'(1);
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall              = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_row            = rsp_row_ff;
   assign rsp_reach_bits         = rsp_bits_ff;
   assign rsp_strongly_connected = rsp_conn_ff;
   assign rsp_last_row           = rsp_last_ff;

endmodule
